@@ rtl/climate_hysteresis_controller_assert.svh @@
// assertion macros used by the controller top level
`ifndef CLIMATE_HYSTERESIS_CONTROLLER_ASSERT_SVH
`define CLIMATE_HYSTERESIS_CONTROLLER_ASSERT_SVH

// clocked assertion with explicit clock and active-low reset
`define CHC_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion on the block clock and reset
`define CHC_ASSERT(label, prop, msg) \
  `CHC_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/chc_pkg.sv @@
// package with types, constants and register codes of the climate controller
`timescale 1ns / 1ps

package chc_pkg;

  localparam int HUM_W  = 10;
  localparam int TEMP_W = 12;
  localparam int ADC_W  = 10;

  localparam int EMA_FRAC_BITS = 8;
  localparam int GAS_W         = ADC_W + EMA_FRAC_BITS;
  localparam int SUM_W         = GAS_W + 3;
  localparam int DIV_SHIFT     = SUM_W + 3;
  localparam int unsigned DIV_RECIP = (2 ** DIV_SHIFT + 4) / 5;
  localparam int PROD_W        = SUM_W + DIV_SHIFT;

  localparam logic [GAS_W-1:0] GAS_MAX = {{ADC_W{1'b1}}, {EMA_FRAC_BITS{1'b0}}};

  localparam int WINDOW_TEMP_TENTHS = 240;
  localparam logic signed [TEMP_W-1:0] WINDOW_TEMP = TEMP_W'(WINDOW_TEMP_TENTHS);

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = GAS_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUM_FAN_ON         = 4'd0,
    REG_HUM_FAN_OFF        = 4'd1,
    REG_HUM_HUMIDIFIER_ON  = 4'd2,
    REG_HUM_HUMIDIFIER_OFF = 4'd3,
    REG_FAN_TEMP_HI        = 4'd4,
    REG_FAN_TEMP_LO        = 4'd5,
    REG_GAS_ALARM_ON       = 4'd6,
    REG_GAS_ALARM_OFF      = 4'd7
  } reg_idx_e;

  typedef struct packed {
    logic [HUM_W-1:0]         hum_fan_on;
    logic [HUM_W-1:0]         hum_fan_off;
    logic [HUM_W-1:0]         hum_humidifier_on;
    logic [HUM_W-1:0]         hum_humidifier_off;
    logic signed [TEMP_W-1:0] fan_temp_hi;
    logic signed [TEMP_W-1:0] fan_temp_lo;
    logic [GAS_W-1:0]         gas_alarm_on;
    logic [GAS_W-1:0]         gas_alarm_off;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    hum_fan_on:         HUM_W'(600),
    hum_fan_off:        HUM_W'(550),
    hum_humidifier_on:  HUM_W'(400),
    hum_humidifier_off: HUM_W'(450),
    fan_temp_hi:        TEMP_W'(240),
    fan_temp_lo:        TEMP_W'(230),
    gas_alarm_on:       GAS_W'(78566),
    gas_alarm_off:      GAS_W'(70710)
  };

  localparam logic [HUM_W-1:0]         HELD_HUM_RESET  = HUM_W'(500);
  localparam logic signed [TEMP_W-1:0] HELD_TEMP_RESET = TEMP_W'(220);

  typedef struct packed {
    logic fan;
    logic humidifier;
    logic alarm;
  } flags_t;

  typedef struct packed {
    logic [HUM_W-1:0]         humidity_in;
    logic signed [TEMP_W-1:0] temperature_in;
    logic                     reading_valid;
    logic [ADC_W-1:0]         gas_sample;
  } in_beat_t;

  typedef struct packed {
    logic                     fan_on;
    logic                     humidifier_on;
    logic                     alarm_on;
    logic                     window_open;
    logic                     valid_out;
    logic [HUM_W-1:0]         humidity_used;
    logic signed [TEMP_W-1:0] temperature_used;
    logic [GAS_W-1:0]         gas_level;
  } out_beat_t;

endpackage

@@ rtl/chc_in_if.sv @@
// sample channel interface
`timescale 1ns / 1ps

interface chc_in_if import chc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/chc_out_if.sv @@
// result channel interface
`timescale 1ns / 1ps

interface chc_out_if import chc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/chc_cfg_regs.sv @@
// threshold register file with plain write port
`timescale 1ns / 1ps

module chc_cfg_regs import chc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HUM_FAN_ON:         cfg_d.hum_fan_on         = cfg_wdata_i[HUM_W-1:0];
        REG_HUM_FAN_OFF:        cfg_d.hum_fan_off        = cfg_wdata_i[HUM_W-1:0];
        REG_HUM_HUMIDIFIER_ON:  cfg_d.hum_humidifier_on  = cfg_wdata_i[HUM_W-1:0];
        REG_HUM_HUMIDIFIER_OFF: cfg_d.hum_humidifier_off = cfg_wdata_i[HUM_W-1:0];
        REG_FAN_TEMP_HI:        cfg_d.fan_temp_hi        = cfg_wdata_i[TEMP_W-1:0];
        REG_FAN_TEMP_LO:        cfg_d.fan_temp_lo        = cfg_wdata_i[TEMP_W-1:0];
        REG_GAS_ALARM_ON:       cfg_d.gas_alarm_on       = cfg_wdata_i[GAS_W-1:0];
        REG_GAS_ALARM_OFF:      cfg_d.gas_alarm_off      = cfg_wdata_i[GAS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/chc_gas_ema.sv @@
// gas exponential average, alpha one fifth, divide by reciprocal multiply
`timescale 1ns / 1ps

module chc_gas_ema import chc_pkg::*; (
  input  logic [ADC_W-1:0] gas_sample_i,
  input  logic [GAS_W-1:0] avg_i,
  output logic [GAS_W-1:0] avg_o
);

  logic [GAS_W-1:0]  scaled;
  logic [GAS_W-1:0]  seed;
  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;

  always_comb begin
    scaled = {gas_sample_i, {EMA_FRAC_BITS{1'b0}}};
    seed   = (avg_i == '0) ? scaled : avg_i;
    sum    = SUM_W'(scaled) + SUM_W'({seed, 2'b00});
    prod   = PROD_W'(sum) * PROD_W'(DIV_RECIP);
    avg_o  = prod[DIV_SHIFT +: GAS_W];
  end

endmodule

@@ rtl/chc_hyst.sv @@
// hysteresis latches for fan, humidifier and gas alarm plus window command
`timescale 1ns / 1ps

module chc_hyst import chc_pkg::*; (
  input  cfg_t                     cfg_i,
  input  flags_t                   flags_i,
  input  logic [HUM_W-1:0]         hum_i,
  input  logic signed [TEMP_W-1:0] temp_i,
  input  logic [GAS_W-1:0]         gas_i,
  output flags_t                   flags_o,
  output logic                     window_o
);

  logic fan_hum, fan_temp, humid, alarm;

  always_comb begin
    // humidity fan latch
    fan_hum = flags_i.fan;
    if (!flags_i.fan && hum_i >= cfg_i.hum_fan_on) begin
      fan_hum = 1'b1;
    end else if (flags_i.fan && hum_i < cfg_i.hum_fan_off) begin
      fan_hum = 1'b0;
    end

    // temperature fan latch
    fan_temp = fan_hum;
    if (!fan_hum && temp_i > cfg_i.fan_temp_hi) begin
      fan_temp = 1'b1;
    end else if (fan_hum && temp_i < cfg_i.fan_temp_lo) begin
      fan_temp = 1'b0;
    end

    humid = flags_i.humidifier;
    if (!flags_i.humidifier && hum_i <= cfg_i.hum_humidifier_on) begin
      humid = 1'b1;
    end else if (flags_i.humidifier && hum_i > cfg_i.hum_humidifier_off) begin
      humid = 1'b0;
    end
    if (fan_temp) begin
      humid = 1'b0;
    end

    alarm = flags_i.alarm;
    if (!flags_i.alarm && gas_i >= cfg_i.gas_alarm_on) begin
      alarm = 1'b1;
    end else if (flags_i.alarm && gas_i < cfg_i.gas_alarm_off) begin
      alarm = 1'b0;
    end

    flags_o.fan        = fan_temp | alarm;
    flags_o.humidifier = humid;
    flags_o.alarm      = alarm;
    window_o           = fan_temp | alarm | (temp_i >= WINDOW_TEMP);
  end

endmodule

@@ rtl/climate_hysteresis_controller.sv @@
// top level of the climate hysteresis controller
`timescale 1ns / 1ps

// One sample beat gives one result beat. A sample is registered on entry and its result
// is computed into the output register when the output stage can take it, where the held
// reading, the gas average and the three latches are updated at the same edge; one
// sample is taken every cycle while the result side keeps taking beats. The result
// stage does the state update: gas average, reciprocal divide by five and the latch
// compares. A sample with reading_valid low reuses the last good humidity and
// temperature. The user must write thresholds through the cfg port only while no beat
// is in flight; the block does not enforce it. An index above the register list is ignored.

module climate_hysteresis_controller import chc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  chc_in_if.sink                sample_i,
  chc_out_if.source             result_o
);

`include "climate_hysteresis_controller_assert.svh"

  cfg_t cfg;

  logic      s1_v_q;
  in_beat_t  s1_q;
  logic      out_v_q;
  out_beat_t out_q, out_d;

  logic [HUM_W-1:0]         held_hum_q, held_hum_d;
  logic signed [TEMP_W-1:0] held_temp_q, held_temp_d;
  logic [GAS_W-1:0]         gas_avg_q, gas_avg_d;
  flags_t                   flags_q, flags_d;
  logic                     window;

  logic advance;
  logic take;

  chc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign advance        = s1_v_q && (!out_v_q || result_o.ready);
  assign sample_i.ready = !s1_v_q || advance;
  assign take           = sample_i.valid && sample_i.ready;

  always_comb begin
    held_hum_d  = held_hum_q;
    held_temp_d = held_temp_q;
    if (s1_q.reading_valid) begin
      held_hum_d  = s1_q.humidity_in;
      held_temp_d = s1_q.temperature_in;
    end
  end

  chc_gas_ema u_ema (
    .gas_sample_i (s1_q.gas_sample),
    .avg_i        (gas_avg_q),
    .avg_o        (gas_avg_d)
  );

  chc_hyst u_hyst (
    .cfg_i    (cfg),
    .flags_i  (flags_q),
    .hum_i    (held_hum_d),
    .temp_i   (held_temp_d),
    .gas_i    (gas_avg_d),
    .flags_o  (flags_d),
    .window_o (window)
  );

  always_comb begin
    out_d.fan_on           = flags_d.fan;
    out_d.humidifier_on    = flags_d.humidifier;
    out_d.alarm_on         = flags_d.alarm;
    out_d.window_open      = window;
    out_d.valid_out        = s1_q.reading_valid;
    out_d.humidity_used    = held_hum_d;
    out_d.temperature_used = held_temp_d;
    out_d.gas_level        = gas_avg_d;
  end

  // control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      out_v_q     <= 1'b0;
      held_hum_q  <= HELD_HUM_RESET;
      held_temp_q <= HELD_TEMP_RESET;
      gas_avg_q   <= '0;
      flags_q     <= '0;
    end else begin
      if (sample_i.ready) begin
        s1_v_q <= sample_i.valid;
      end
      if (advance) begin
        out_v_q     <= 1'b1;
        held_hum_q  <= held_hum_d;
        held_temp_q <= held_temp_d;
        gas_avg_q   <= gas_avg_d;
        flags_q     <= flags_d;
      end else if (result_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_q <= sample_i.data;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign result_o.valid = out_v_q;
  assign result_o.data  = out_q;

  `CHC_ASSERT(a_gas_bounded, gas_avg_q <= GAS_MAX, "gas average above full scale")
  `CHC_ASSERT(a_alarm_forces_fan, out_v_q && out_q.alarm_on |-> out_q.fan_on, "alarm without fan")
  `CHC_ASSERT(a_humid_excl_fan, out_v_q && out_q.humidifier_on && !out_q.alarm_on |-> !out_q.fan_on, "fan and humidifier together")
  `CHC_ASSERT(a_advance_shows, advance |=> out_v_q && out_q.gas_level == gas_avg_q, "result beat lost")

endmodule

@@ tb/sv/tb_climate_hysteresis_controller.sv @@
// self-checking testbench for the climate controller: directed sample table, then random sensor walks
`timescale 1ns / 1ps

module tb_climate_hysteresis_controller;
  import chc_pkg::*;

  localparam int CLK_PERIOD         = 10;
  localparam int RESET_CYCLES       = 6;
  localparam int RANDOM_PER_SETTING = 80;
  localparam int SETTING_COUNT      = 6;
  localparam int DRAIN_CYCLES       = 10;
  localparam int STALL_LIMIT        = 2000;
  localparam int VALID_PCT          = 85;

  localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_FIRST = CFG_IDX_W'(REG_GAS_ALARM_OFF + 1);
  localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED_LAST  = '1;

  typedef enum int {
    SET_RESET,
    SET_RANGE_LOW,
    SET_RANGE_HIGH,
    SET_RAW_ONES,
    SET_RAW_RANDOM,
    SET_SPREAD
  } setting_e;

  typedef struct packed {
    in_beat_t  smp;
    logic      pinned;
    out_beat_t res;
  } sample_row_t;

  localparam out_beat_t NO_PIN = '0;

  localparam sample_row_t DIRECTED_ROWS [22] = '{
    '{'{10'd0,    12'sd0,    1'b0, 10'd0},    1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 10'd500, 12'sd220, 18'd0}},
    '{'{10'd1000, 12'sd1250, 1'b1, 10'd1023}, 1'b1,
      '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 10'd1000, 12'sd1250, 18'd261888}},
    '{'{10'd0,    -12'sd400, 1'b1, 10'd1023}, 1'b0, NO_PIN},
    '{'{10'd1023, 12'sd2047, 1'b0, 10'd1023}, 1'b0, NO_PIN},
    '{'{10'd1023, 12'h800,   1'b1, 10'd0},    1'b0, NO_PIN},
    '{'{10'd500,  12'sd220,  1'b1, 10'd0},    1'b0, NO_PIN},
    '{'{10'd500,  12'sd220,  1'b0, 10'd0},    1'b0, NO_PIN},
    '{'{10'd500,  12'sd220,  1'b1, 10'd0},    1'b0, NO_PIN},
    '{'{10'd500,  12'sd220,  1'b1, 10'd0},    1'b0, NO_PIN},
    '{'{10'd500,  12'sd220,  1'b1, 10'd0},    1'b0, NO_PIN},
    '{'{10'd599,  12'sd220,  1'b1, 10'd0},    1'b0, NO_PIN},
    '{'{10'd600,  12'sd220,  1'b1, 10'd0},    1'b0, NO_PIN},
    '{'{10'd550,  12'sd220,  1'b1, 10'd0},    1'b0, NO_PIN},
    '{'{10'd549,  12'sd220,  1'b1, 10'd0},    1'b0, NO_PIN},
    '{'{10'd400,  12'sd220,  1'b1, 10'd0},    1'b0, NO_PIN},
    '{'{10'd450,  12'sd220,  1'b1, 10'd0},    1'b0, NO_PIN},
    '{'{10'd451,  12'sd220,  1'b1, 10'd0},    1'b0, NO_PIN},
    '{'{10'd400,  12'sd241,  1'b1, 10'd0},    1'b0, NO_PIN},
    '{'{10'd400,  12'sd230,  1'b1, 10'd0},    1'b0, NO_PIN},
    '{'{10'd500,  12'sd229,  1'b1, 10'd0},    1'b0, NO_PIN},
    '{'{10'd500,  12'sd240,  1'b1, 10'd0},    1'b0, NO_PIN},
    '{'{10'd500,  12'sd240,  1'b0, 10'd512},  1'b0, NO_PIN}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  chc_in_if  sample_if ();
  chc_out_if result_if ();

  climate_hysteresis_controller DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (sample_if),
    .result_o    (result_if)
  );

  // controller shadow state
  cfg_t                     cfg_shadow;
  logic [HUM_W-1:0]         held_hum;
  logic signed [TEMP_W-1:0] held_temp;
  logic [GAS_W-1:0]         gas_avg;
  flags_t                   latch;

  out_beat_t expected_q [$];
  out_beat_t got_res;
  out_beat_t want_res;
  int        mismatch_cnt = 0;
  int        checked_cnt  = 0;
  int        stall_cycles = 0;
  int        snd_idle_pct = 0;
  int        rcv_idle_pct = 0;

  // random sensor walks
  int hum_walk   = 500;
  int temp_walk  = 220;
  int gas_target = 300;

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  function automatic out_beat_t predict_result(input in_beat_t smp);
    logic [HUM_W-1:0]         hum;
    logic signed [TEMP_W-1:0] temp;
    logic signed [TEMP_W-1:0] t_on;
    logic signed [TEMP_W-1:0] t_off;
    int unsigned              s;
    out_beat_t                res;
    if (smp.reading_valid) begin
      held_hum  = smp.humidity_in;
      held_temp = smp.temperature_in;
    end
    hum   = held_hum;
    temp  = held_temp;
    t_on  = cfg_shadow.fan_temp_hi;
    t_off = cfg_shadow.fan_temp_lo;

    // ema with alpha one fifth, seeded when empty
    s = smp.gas_sample;
    s = s << EMA_FRAC_BITS;
    if (gas_avg == '0) gas_avg = GAS_W'(s);
    gas_avg = GAS_W'((s + 4 * gas_avg) / 5);

    if (!latch.fan && hum >= cfg_shadow.hum_fan_on) latch.fan = 1'b1;
    else if (latch.fan && hum < cfg_shadow.hum_fan_off) latch.fan = 1'b0;
    if (!latch.fan && temp > t_on) latch.fan = 1'b1;
    else if (latch.fan && temp < t_off) latch.fan = 1'b0;

    if (!latch.humidifier && hum <= cfg_shadow.hum_humidifier_on) latch.humidifier = 1'b1;
    else if (latch.humidifier && hum > cfg_shadow.hum_humidifier_off) latch.humidifier = 1'b0;
    if (latch.fan && latch.humidifier) latch.humidifier = 1'b0;

    if (!latch.alarm && gas_avg >= cfg_shadow.gas_alarm_on) latch.alarm = 1'b1;
    else if (latch.alarm && gas_avg < cfg_shadow.gas_alarm_off) latch.alarm = 1'b0;
    if (latch.alarm) latch.fan = 1'b1;

    res.fan_on           = latch.fan;
    res.humidifier_on    = latch.humidifier;
    res.alarm_on         = latch.alarm;
    res.window_open      = latch.fan || latch.alarm || (temp >= WINDOW_TEMP);
    res.valid_out        = smp.reading_valid;
    res.humidity_used    = hum;
    res.temperature_used = temp;
    res.gas_level        = gas_avg;
    return res;
  endfunction

  function automatic in_beat_t next_sample();
    in_beat_t smp;
    int       gas;
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 5))
        0:       hum_walk = cfg_shadow.hum_fan_on;
        1:       hum_walk = cfg_shadow.hum_fan_off;
        2:       hum_walk = cfg_shadow.hum_humidifier_on;
        3:       hum_walk = cfg_shadow.hum_humidifier_off;
        4:       hum_walk = $urandom_range(0, 1000);
        default: hum_walk = $urandom_range(0, (1 << HUM_W) - 1);
      endcase
    end else begin
      hum_walk += int'($urandom_range(0, 12)) - 6;
    end

    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 4))
        0:       temp_walk = int'($signed(cfg_shadow.fan_temp_hi));
        1:       temp_walk = int'($signed(cfg_shadow.fan_temp_lo));
        2:       temp_walk = WINDOW_TEMP_TENTHS;
        3:       temp_walk = int'($urandom_range(0, 1650)) - 400;
        default: temp_walk = $urandom_range(0, (1 << TEMP_W) - 1);
      endcase
    end else begin
      temp_walk += int'($urandom_range(0, 8)) - 4;
    end

    // zero runs last long enough for the average to decay and reseed
    if ($urandom_range(0, (gas_target == 0) ? 59 : 19) == 0) begin
      case ($urandom_range(0, 4))
        0:       gas_target = 0;
        1:       gas_target = (1 << ADC_W) - 1;
        2:       gas_target = int'(cfg_shadow.gas_alarm_on >> EMA_FRAC_BITS);
        3:       gas_target = int'(cfg_shadow.gas_alarm_off >> EMA_FRAC_BITS);
        default: gas_target = $urandom_range(0, (1 << ADC_W) - 1);
      endcase
    end
    gas = gas_target;
    if (gas_target != 0) gas += int'($urandom_range(0, 16)) - 8;
    if (gas < 0) gas = 0;
    else if (gas > (1 << ADC_W) - 1) gas = (1 << ADC_W) - 1;

    smp.humidity_in    = HUM_W'(hum_walk);
    smp.temperature_in = TEMP_W'(temp_walk);
    smp.reading_valid  = ($urandom_range(0, 99) < VALID_PCT);
    smp.gas_sample     = ADC_W'(gas);
    return smp;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at result %0d: %s", checked_cnt, what);
    mismatch_cnt++;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] got,
                             input logic signed [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      REG_HUM_FAN_ON:         cfg_shadow.hum_fan_on         = data[HUM_W-1:0];
      REG_HUM_FAN_OFF:        cfg_shadow.hum_fan_off        = data[HUM_W-1:0];
      REG_HUM_HUMIDIFIER_ON:  cfg_shadow.hum_humidifier_on  = data[HUM_W-1:0];
      REG_HUM_HUMIDIFIER_OFF: cfg_shadow.hum_humidifier_off = data[HUM_W-1:0];
      REG_FAN_TEMP_HI:        cfg_shadow.fan_temp_hi        = data[TEMP_W-1:0];
      REG_FAN_TEMP_LO:        cfg_shadow.fan_temp_lo        = data[TEMP_W-1:0];
      REG_GAS_ALARM_ON:       cfg_shadow.gas_alarm_on       = data[GAS_W-1:0];
      REG_GAS_ALARM_OFF:      cfg_shadow.gas_alarm_off      = data[GAS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_setting(input setting_e kind);
    cfg_t                  tgt;
    logic [CFG_DATA_W-1:0] data;
    reg_idx_e              r;
    case (kind)
      SET_RESET:      tgt = CFG_RESET;
      SET_RANGE_LOW:  tgt = '{10'd0, 10'd0, 10'd0, 10'd0, -12'sd400, -12'sd400, '0, '0};
      SET_RANGE_HIGH: tgt = '{10'd1000, 10'd1000, 10'd1000, 10'd1000, 12'sd1250, 12'sd1250,
                              GAS_MAX, GAS_MAX};
      SET_SPREAD: begin
        tgt.hum_fan_off        = HUM_W'($urandom_range(300, 900));
        tgt.hum_fan_on         = tgt.hum_fan_off + HUM_W'($urandom_range(0, 100));
        tgt.hum_humidifier_on  = HUM_W'($urandom_range(100, 500));
        tgt.hum_humidifier_off = tgt.hum_humidifier_on + HUM_W'($urandom_range(0, 100));
        tgt.fan_temp_lo        = TEMP_W'(int'($urandom_range(0, 700)) - 100);
        tgt.fan_temp_hi        = tgt.fan_temp_lo + TEMP_W'($urandom_range(0, 50));
        tgt.gas_alarm_off      = GAS_W'($urandom_range(50, 600) << EMA_FRAC_BITS);
        tgt.gas_alarm_on       = tgt.gas_alarm_off + GAS_W'($urandom_range(0, 15000));
      end
      default:        tgt = '0;
    endcase
    r = r.first();
    do begin
      case (r)
        REG_HUM_FAN_ON:         data = CFG_DATA_W'(tgt.hum_fan_on);
        REG_HUM_FAN_OFF:        data = CFG_DATA_W'(tgt.hum_fan_off);
        REG_HUM_HUMIDIFIER_ON:  data = CFG_DATA_W'(tgt.hum_humidifier_on);
        REG_HUM_HUMIDIFIER_OFF: data = CFG_DATA_W'(tgt.hum_humidifier_off);
        REG_FAN_TEMP_HI:        data = CFG_DATA_W'(tgt.fan_temp_hi);
        REG_FAN_TEMP_LO:        data = CFG_DATA_W'(tgt.fan_temp_lo);
        REG_GAS_ALARM_ON:       data = CFG_DATA_W'(tgt.gas_alarm_on);
        REG_GAS_ALARM_OFF:      data = CFG_DATA_W'(tgt.gas_alarm_off);
        default:                data = '0;
      endcase
      if (kind == SET_RAW_ONES) data = '1;
      else if (kind == SET_RAW_RANDOM) data = CFG_DATA_W'($urandom);
      cfg_write(r, data);
      r = r.next();
    end while (r != r.first());
    cfg_write(CFG_IDX_W'($urandom_range(IDX_UNMAPPED_FIRST, IDX_UNMAPPED_LAST)),
              CFG_DATA_W'($urandom));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_sample(input in_beat_t smp, input logic pinned, input out_beat_t pin_res);
    out_beat_t res;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_if.valid <= 1'b1;
    sample_if.data  <= smp;
    do @(posedge clk_i); while (sample_if.ready !== 1'b1);
    res = predict_result(smp);
    expected_q.push_back(pinned ? pin_res : res);
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      result_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // result beat checker and stall watchdog
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((sample_if.valid && sample_if.ready) === 1'b1 ||
          (result_if.valid && result_if.ready) === 1'b1) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("climate_hysteresis_controller regression: fail");
        $finish;
      end else if ((result_if.valid && result_if.ready) === 1'b1) begin
        got_res = result_if.data;
        if (expected_q.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want_res = expected_q.pop_front();
          check_field("fan_on", got_res.fan_on, want_res.fan_on);
          check_field("humidifier_on", got_res.humidifier_on, want_res.humidifier_on);
          check_field("alarm_on", got_res.alarm_on, want_res.alarm_on);
          check_field("window_open", got_res.window_open, want_res.window_open);
          check_field("valid_out", got_res.valid_out, want_res.valid_out);
          check_field("humidity_used", got_res.humidity_used, want_res.humidity_used);
          check_field("temperature_used", $signed(got_res.temperature_used),
                      $signed(want_res.temperature_used));
          check_field("gas_level", got_res.gas_level, want_res.gas_level);
        end
        checked_cnt++;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_wdata_i     = '0;
    sample_if.valid = 1'b0;
    sample_if.data  = '0;
    cfg_shadow      = CFG_RESET;
    held_hum        = HELD_HUM_RESET;
    held_temp       = HELD_TEMP_RESET;
    gas_avg         = '0;
    latch           = '0;
    snd_idle_pct    = 35;
    rcv_idle_pct    = 63;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // writes to unmapped indexes must leave the reset thresholds alone
    cfg_write(IDX_UNMAPPED_FIRST, '1);
    cfg_write(IDX_UNMAPPED_LAST, '1);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;

    foreach (DIRECTED_ROWS[i])
      send_sample(DIRECTED_ROWS[i].smp, DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].res);

    for (int seg = 0; seg < SETTING_COUNT; seg++) begin
      sample_if.valid <= 1'b0;
      wait_drained();
      case (seg / 2)
        0: begin
          snd_idle_pct = 35;
          rcv_idle_pct = 63;
        end
        1: begin
          snd_idle_pct = 63;
          rcv_idle_pct = 35;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      program_setting(setting_e'(seg));
      repeat (RANDOM_PER_SETTING) send_sample(next_sample(), 1'b0, NO_PIN);
    end

    sample_if.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("climate_hysteresis_controller regression: pass");
    end else begin
      $display("climate_hysteresis_controller regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/chc_pkg.sv
rtl/chc_in_if.sv
rtl/chc_out_if.sv
rtl/chc_cfg_regs.sv
rtl/chc_gas_ema.sv
rtl/chc_hyst.sv
rtl/climate_hysteresis_controller.sv
tb/sv/tb_climate_hysteresis_controller.sv
